// ===== hw/rtl/mef_pkg.sv =====
// shared types and constants for the fixed-point escape-time engine
package mef_pkg;

  // fixed-point format of c and of the multiplier operands
  localparam int OPER_W    = 32;
  localparam int FRAC_BITS = 28;
  localparam int PROD_W    = 2 * OPER_W;
  localparam int SQ_W      = PROD_W - FRAC_BITS;
  // z after squaring and the add of c stays within +/- 2^36
  localparam int Z_W       = SQ_W + 1;

  // escape when re^2 + im^2 exceeds 4.0
  localparam logic [Z_W-1:0] ESCAPE_LIMIT = Z_W'(64'd4 << FRAC_BITS);

  // snapshot refreshed every PERIOD_INTERVAL + 1 iterations
  localparam int PERIOD_INTERVAL = 20;
  localparam int WAIT_W = $clog2(PERIOD_INTERVAL + 1);

  // configuration registers
  localparam int ITER_W    = 16;
  localparam int SQ_CNT_W  = 4;
  localparam int CFG_W     = ITER_W;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARINGS      = 1'd1;
  localparam logic [ITER_W-1:0]    MAX_ITER_RESET     = 16'd255;
  localparam logic [SQ_CNT_W-1:0]  SQUARINGS_RESET    = 4'd1;

  // result codes
  localparam int OUTCOME_W = 2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_LIMIT    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_ESCAPED  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_PERIODIC = 2'd2;

  // job queue between front and back (depth must be a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [OPER_W-1:0] c_re;
    logic signed [OPER_W-1:0] c_im;
    logic [ITER_W-1:0]        limit;
    logic [SQ_CNT_W-1:0]      nsq;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD,
    BK_DONE
  } back_state_t;

endpackage

// ===== hw/rtl/mef_front.sv =====
// front end: accepts points, attaches the run settings and queues the jobs
module mef_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mef_pkg::OPER_W-1:0] in_c_re,
  input  logic signed [mef_pkg::OPER_W-1:0] in_c_im,
  input  logic [mef_pkg::ITER_W-1:0]        max_iter,
  input  logic [mef_pkg::SQ_CNT_W-1:0]      squarings,
  output logic                              job_valid,
  input  logic                              job_pop,
  output mef_pkg::job_t                     job
);
  import mef_pkg::*;

  job_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;
  job_t              new_job;

  assign in_stall  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign job_valid = (cnt_r != '0);
  assign pop       = job_pop && job_valid;
  assign job       = ent_r[rd_ptr_r];

  // zero squarings behaves as one
  always_comb begin
    new_job.c_re  = in_c_re;
    new_job.c_im  = in_c_im;
    new_job.limit = max_iter;
    new_job.nsq   = (squarings == '0) ? SQ_CNT_W'(1) : squarings;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mef_back.sv =====
// back end: iterates z for one job at a time and holds the result
module mef_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  output logic                           job_pop,
  input  mef_pkg::job_t                  job,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mef_pkg::ITER_W-1:0]     out_count_left,
  output logic [mef_pkg::OUTCOME_W-1:0]  out_outcome
);
  import mef_pkg::*;

  back_state_t state_r, state_nxt;

  logic signed [OPER_W-1:0] cr_r, ci_r;
  logic signed [Z_W-1:0]    zr_r, zi_r;
  logic signed [Z_W-1:0]    snr_r, sni_r;
  logic [WAIT_W-1:0]        wait_r;
  logic [ITER_W-1:0]        count_r;
  logic [SQ_CNT_W-1:0]      nsq_r, sq_left_r;
  logic signed [PROD_W-1:0] prr_r, pii_r, pri_r;
  logic [ITER_W-1:0]        res_count_r;
  logic [OUTCOME_W-1:0]     res_code_r;

  logic signed [SQ_W-1:0] r2, i2, ri;
  logic signed [Z_W-1:0]  r2_x, i2_x, ri_x;
  logic signed [Z_W-1:0]  zr_sq, zi_sq, zr_c, zi_c;
  logic [Z_W-1:0]         mag;
  logic                   last_sq, escaped, periodic, limit_hit, finish;
  logic [ITER_W-1:0]      count_dec;

  // floor shift of the products
  assign r2   = prr_r[PROD_W-1:FRAC_BITS];
  assign i2   = pii_r[PROD_W-1:FRAC_BITS];
  assign ri   = pri_r[PROD_W-1:FRAC_BITS];
  assign r2_x = {{(Z_W-SQ_W){r2[SQ_W-1]}}, r2};
  assign i2_x = {{(Z_W-SQ_W){i2[SQ_W-1]}}, i2};
  assign ri_x = {{(Z_W-SQ_W){ri[SQ_W-1]}}, ri};

  assign zr_sq = r2_x - i2_x;
  assign zi_sq = ri_x + ri_x;
  // both squares are non-negative
  assign mag   = $unsigned(r2_x) + $unsigned(i2_x);
  assign zr_c  = zr_sq + {{(Z_W-OPER_W){cr_r[OPER_W-1]}}, cr_r};
  assign zi_c  = zi_sq + {{(Z_W-OPER_W){ci_r[OPER_W-1]}}, ci_r};

  assign last_sq   = (sq_left_r == SQ_CNT_W'(1));
  assign escaped   = last_sq && (mag > ESCAPE_LIMIT);
  assign periodic  = last_sq && !escaped && (zr_c == snr_r) && (zi_c == sni_r);
  assign count_dec = count_r - ITER_W'(1);
  assign limit_hit = last_sq && !escaped && !periodic && (count_dec == '0);
  assign finish    = escaped || periodic || limit_hit;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (job_valid) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_UPD;
      BK_UPD:  state_nxt = finish ? BK_DONE : BK_MUL;
      BK_DONE: if (!out_stall) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    job_pop   = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: job_pop = job_valid;
      BK_DONE: out_valid = 1'b1;
      default: begin
        job_pop   = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          cr_r      <= job.c_re;
          ci_r      <= job.c_im;
          zr_r      <= {{(Z_W-OPER_W){job.c_re[OPER_W-1]}}, job.c_re};
          zi_r      <= {{(Z_W-OPER_W){job.c_im[OPER_W-1]}}, job.c_im};
          snr_r     <= {{(Z_W-OPER_W){job.c_re[OPER_W-1]}}, job.c_re};
          sni_r     <= {{(Z_W-OPER_W){job.c_im[OPER_W-1]}}, job.c_im};
          wait_r    <= WAIT_W'(PERIOD_INTERVAL);
          count_r   <= job.limit;
          nsq_r     <= job.nsq;
          sq_left_r <= job.nsq;
        end
      end
      BK_MUL: begin
        // operands are the low 32 bits of z, signed
        prr_r <= $signed(zr_r[OPER_W-1:0]) * $signed(zr_r[OPER_W-1:0]);
        pii_r <= $signed(zi_r[OPER_W-1:0]) * $signed(zi_r[OPER_W-1:0]);
        pri_r <= $signed(zr_r[OPER_W-1:0]) * $signed(zi_r[OPER_W-1:0]);
      end
      BK_UPD: begin
        if (!last_sq) begin
          zr_r      <= zr_sq;
          zi_r      <= zi_sq;
          sq_left_r <= sq_left_r - SQ_CNT_W'(1);
        end else begin
          zr_r      <= zr_c;
          zi_r      <= zi_c;
          sq_left_r <= nsq_r;
          count_r   <= count_dec;
          if (wait_r == '0) begin
            snr_r  <= zr_c;
            sni_r  <= zi_c;
            wait_r <= WAIT_W'(PERIOD_INTERVAL);
          end else begin
            wait_r <= wait_r - WAIT_W'(1);
          end
        end
        if (escaped) begin
          res_count_r <= count_r;
          res_code_r  <= OUTCOME_ESCAPED;
        end else if (periodic) begin
          res_count_r <= '0;
          res_code_r  <= OUTCOME_PERIODIC;
        end else begin
          res_count_r <= '0;
          res_code_r  <= OUTCOME_LIMIT;
        end
      end
      default: begin
        res_count_r <= res_count_r;
      end
    endcase
  end

  assign out_count_left = res_count_r;
  assign out_outcome    = res_code_r;

endmodule

// ===== hw/rtl/mandelbrot_escape_fixed.sv =====
// top level: escape-time iteration of one point c in signed 4.28 fixed point
// a point is queued, then popped by the idle engine and iterated until it finishes,
//   with S squarings per iteration; each squaring is a multiply and an update state
// one point at a time in the engine; a two-entry job queue keeps taking points until full
// reset: synchronous active-low rst_n empties the queue, idles the engine and
//   sets max_iterations to 255 and squarings_per_step to 1
module mandelbrot_escape_fixed (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [mef_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mef_pkg::CFG_W-1:0]         cfg_wdata,
  // point input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mef_pkg::OPER_W-1:0] in_c_re,
  input  logic signed [mef_pkg::OPER_W-1:0] in_c_im,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mef_pkg::ITER_W-1:0]        out_count_left,
  output logic [mef_pkg::OUTCOME_W-1:0]     out_outcome
);
  import mef_pkg::*;

  logic [ITER_W-1:0]   max_iter_r;
  logic [SQ_CNT_W-1:0] squarings_r;

  logic job_valid;
  logic job_pop;
  job_t job;

  // configuration registers, written only while the block is idle; the user must ensure it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= MAX_ITER_RESET;
      squarings_r <= SQUARINGS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ITERATIONS: max_iter_r  <= cfg_wdata;
        CFG_SQUARINGS:      squarings_r <= cfg_wdata[SQ_CNT_W-1:0];
        default:            max_iter_r  <= max_iter_r;
      endcase
    end
  end

  // front: takes each transfer, snapshots the settings and queues the job
  mef_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_c_re   (in_c_re),
    .in_c_im   (in_c_im),
    .max_iter  (max_iter_r),
    .squarings (squarings_r),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  // back: runs the iteration and holds the result until it is taken
  mef_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (job_valid),
    .job_pop        (job_pop),
    .job            (job),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_count_left (out_count_left),
    .out_outcome    (out_outcome)
  );

endmodule
